FILE: src/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: assertion failed");

`endif

FILE: src/tdpt_pkg.sv
// Shared widths, constants and controller/datapath interface types.
package tdpt_pkg;

   localparam int VALUE_BITS = 31;
   // wide enough to hold floor(sqrt(max value)) + 1
   localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQ_BITS    = 2 * DIV_BITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [DIV_BITS-1:0]   divisor_type;
   typedef logic [SQ_BITS-1:0]    square_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   localparam divisor_type DIV_FIRST = DIV_BITS'(2);
   localparam count_type   CNT_LAST  = CNT_BITS'(VALUE_BITS - 1);

   typedef struct packed {
      logic load;       // capture candidate, divisor = 2, start remainder
      logic step;       // one restoring remainder step
      logic next_div;   // advance divisor, restart remainder
   } cmd_type;

   typedef struct packed {
      logic sq_gt_n;    // divisor squared exceeds candidate
      logic rem_zero;   // remainder is zero
      logic div_last;   // current step is the last remainder step
   } status_type;

endpackage

FILE: src/tdpt_datapath.sv
// Datapath: candidate and divisor registers, squarer and bit-serial remainder unit.
module tdpt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tdpt_pkg::value_type  candidate,
   input  tdpt_pkg::cmd_type    cmd,
   output tdpt_pkg::status_type status
);
   import tdpt_pkg::*;
   `include "assert_macros.svh"

   value_type   n_ff, n_in;
   value_type   shift_ff, shift_in;
   divisor_type d_ff, d_in;
   divisor_type rem_ff, rem_in;
   square_type  sq_ff, sq_in;
   count_type   cnt_ff, cnt_in;

   logic [DIV_BITS:0] trial;
   logic [DIV_BITS:0] diff;

   // restoring remainder: bring in one candidate bit, MSB first
   assign trial = {rem_ff, shift_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      n_in     = n_ff;
      d_in     = d_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      // d is stable over the whole remainder pass, so the square settles early
      sq_in    = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);
      if (cmd.load) begin
         n_in     = candidate;
         d_in     = DIV_FIRST;
         shift_in = candidate;
         rem_in   = '0;
         cnt_in   = CNT_LAST;
      end else if (cmd.next_div) begin
         d_in     = d_ff + DIV_BITS'(1);
         shift_in = n_ff;
         rem_in   = '0;
         cnt_in   = CNT_LAST;
      end else if (cmd.step) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         // borrow out means the divisor did not fit
         rem_in   = diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
         cnt_in   = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      sq_ff    <= sq_in;
   end

   assign status.sq_gt_n  = sq_ff > SQ_BITS'(n_ff);
   assign status.rem_zero = (rem_ff == '0);
   assign status.div_last = (cnt_ff == '0);

   `ASSERT_NEXT(a_load_init, clock, reset, cmd.load,
      d_ff == DIV_FIRST && cnt_ff == CNT_LAST && rem_ff == '0)
   `ASSERT_NEXT(a_next_div, clock, reset, cmd.next_div && !cmd.load,
      d_ff == $past(d_ff) + DIV_BITS'(1))

endmodule

FILE: src/tdpt_ctrl.sv
// Controller: sequences the divisor loop and holds the result register.
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_prime,
   output tdpt_pkg::cmd_type    cmd,
   input  tdpt_pkg::status_type status
);
   import tdpt_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_TEST,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      verdict_ff;
   logic      rsp_valid_ff;
   logic      is_prime_ff;
   logic      rsp_load;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = is_prime_ff;

   assign cmd.load     = req_valid && (state_ff == ST_IDLE);
   assign cmd.step     = (state_ff == ST_DIVIDE);
   assign cmd.next_div = (state_ff == ST_TEST) && !status.sq_gt_n && !status.rem_zero;

   // wait for the output register to be free
   assign rsp_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         verdict_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         is_prime_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            is_prime_ff  <= verdict_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               // limit check comes first: a candidate equal to d is prime
               if (status.sq_gt_n) begin
                  verdict_ff <= 1'b1;
                  state_ff   <= ST_FINISH;
               end else if (status.rem_zero) begin
                  verdict_ff <= 1'b0;
                  state_ff   <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_DIVIDE)
   `ASSERT_NEXT(a_pass_ends, clock, reset, state_ff == ST_DIVIDE && status.div_last,
      state_ff == ST_TEST)
   `ASSERT_IMPLY(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_ready)

endmodule

FILE: src/trial_division_prime_test.sv
// Each trial divisor takes 31 remainder steps and one test.
// A prime n tries floor(sqrt(n)) divisors; a composite stops at its smallest factor.
// The worst case at 31 bits is set by the bit-serial remainder unit.
// One transaction in flight; a finished result may wait in the output register.
// Reset is synchronous, active high, and clears the controller and output valid.
module trial_division_prime_test (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tdpt_pkg::value_type req_candidate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_prime
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the trial division prime tester: directed table, then random mix.
`timescale 1ns / 100ps

module tb_top;
   import tdpt_pkg::*;

   localparam int  RESET_CYCLES = 12;
   localparam int  RANDOM_ITEMS = 80;
   localparam int  HOLD_AT      = 40;     // result count at which the receiver stalls
   localparam int  LONG_HOLD    = 5000;
   localparam int  DRAIN_CYCLES = 100;
   // the max 31-bit prime alone dominates the run time; the rest is small
   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int  SMALL_MAX    = 4095;

   typedef struct packed {
      value_type cand;
      logic      fixed;   // expected answer given in the row
      logic      want;
   } probe_row_type;

   typedef enum int {PICK_SMALL, PICK_WALK, PICK_EVEN, PICK_MULTIPLE} pick_kind_type;

   localparam int N_DIRECTED = 20;
   localparam probe_row_type DIRECTED [N_DIRECTED] = '{
      '{31'd0,          1'b1, 1'b1},   // below two: no divisor tried
      '{31'd1,          1'b1, 1'b1},
      '{31'd2,          1'b1, 1'b1},
      '{31'd3,          1'b1, 1'b1},
      '{31'd4,          1'b1, 1'b0},
      '{31'd9,          1'b1, 1'b0},
      '{31'd25,         1'b1, 1'b0},
      '{31'd49,         1'b1, 1'b0},
      '{31'd169,        1'b1, 1'b0},
      '{31'd97,         1'b0, 1'b0},
      '{31'd1023,       1'b0, 1'b0},
      '{31'd4096,       1'b1, 1'b0},
      '{31'd65521,      1'b0, 1'b0},
      '{31'h7FFFFFFE,   1'b1, 1'b0},
      '{31'h7FFFFFFD,   1'b0, 1'b0},
      '{31'h55555555,   1'b0, 1'b0},
      '{31'h2AAAAAAA,   1'b1, 1'b0},
      '{31'h40000000,   1'b1, 1'b0},
      '{31'd65536,      1'b1, 1'b0},
      '{31'h7FFFFFFF,   1'b0, 1'b0}    // largest value, worst-case run
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   value_type req_candidate = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_is_prime;

   bit            verdict_q [$];
   probe_row_type probe_q [$];
   bit            all_sent = 1'b0;
   int            fail_count = 0;
   int            checked = 0;
   int            primes_seen = 0;
   longint        cycle_count = 0;

   trial_division_prime_test DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_prime  (rsp_is_prime)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // expected answer: try divisors while d <= n / d
   function automatic bit prime_by_trial(value_type n);
      longint unsigned num;
      longint unsigned d;
      num = longint'(n);
      for (d = 2; d <= num / d; d++) begin
         if (num % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic value_type random_candidate(pick_kind_type kind);
      int unsigned p;
      int unsigned m;
      value_type   v;
      case (kind)
         PICK_SMALL: begin
            v = value_type'($urandom_range(0, SMALL_MAX));
         end
         PICK_EVEN: begin
            v = value_type'($urandom());
            v[0] = 1'b0;
         end
         default: begin
            // large value with a small factor keeps the search short
            case ($urandom_range(0, 4))
               0: p = 3;
               1: p = 5;
               2: p = 7;
               3: p = 11;
               default: p = 13;
            endcase
            m = $urandom_range(1, 32'h7FFF_FFFF / p);
            v = value_type'(m * p);
         end
      endcase
      return v;
   endfunction

   task automatic build_stimulus();
      int            n;
      int            run;
      int            base;
      int            sel;
      pick_kind_type kind;
      probe_row_type row;
      for (int i = 0; i < N_DIRECTED; i++) probe_q.push_back(DIRECTED[i]);
      n = 0;
      while (n < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 45)      kind = PICK_SMALL;
         else if (sel < 65) kind = PICK_WALK;
         else if (sel < 85) kind = PICK_EVEN;
         else               kind = PICK_MULTIPLE;
         row.fixed = 1'b0;
         row.want  = 1'b0;
         if (kind == PICK_WALK) begin
            // consecutive values, as a range walk would feed them
            run  = $urandom_range(4, 10);
            base = $urandom_range(2, SMALL_MAX - 10);
            for (int k = 0; k < run && n < RANDOM_ITEMS; k++) begin
               row.cand = value_type'(base + k);
               probe_q.push_back(row);
               n++;
            end
         end else begin
            row.cand = random_candidate(kind);
            probe_q.push_back(row);
            n++;
         end
      end
   endtask

   // sender
   initial begin
      int            gap;
      bit            quiet;
      bit            verdict;
      probe_row_type row;
      build_stimulus();
      quiet = 1'b0;
      while (reset) @(posedge clock);
      for (int i = 0; i < probe_q.size(); i++) begin
         row = probe_q[i];
         if (i % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_candidate <= row.cand;
         do @(posedge clock); while (!req_ready);
         verdict = row.fixed ? row.want : prime_by_trial(row.cand);
         verdict_q.push_back(verdict);
      end
      req_valid <= 1'b0;
      all_sent = 1'b1;
   end

   // receiver and checker
   initial begin
      int  gap;
      bit  quiet;
      bit  want;
      quiet = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (checked % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
         gap = quiet ? 0 : $urandom_range(0, 3);
         // one long stall so the block backs up into its input
         if (checked == HOLD_AT) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (verdict_q.size() == 0) begin
            $error("is_prime: unexpected transaction, value %0b", rsp_is_prime);
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_is_prime !== want) begin
               $error("is_prime: expected %0b, actual %0b", want, rsp_is_prime);
               fail_count++;
            end
         end
         if (rsp_is_prime === 1'b1) primes_seen++;
         checked++;
      end
   end

   // timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, verdict_q.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (!all_sent || verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Tested %0d candidates (%0d from the directed table), %0d answered prime",
               checked, N_DIRECTED, primes_seen);
      $display("Included values 0 and 1, the 31-bit extremes and a %0d-cycle receiver stall",
               LONG_HOLD);
      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
